// ----- hdl/cbrs_pkg.sv -----
// ----------------------------------------------------------------------------
// cbrs_pkg: card block read sequencer package
// Field widths, action and phase codes, card status words and the table of
// the five file blocks read from the card.
// ----------------------------------------------------------------------------
package cbrs_pkg;

  // field widths of the request and result channels
  localparam int SW_W    = 16;
  localparam int CHUNK_W = 9;
  localparam int ACT_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int DLEN_W  = 3;
  localparam int BLK_W   = 3;
  localparam int COUNT_W = 12;
  localparam int PH_W    = 2;

  localparam logic [BLK_W-1:0] NBLOCKS = 3'd5;

  // request types
  localparam logic REQ_START    = 1'b0;
  localparam logic REQ_RESPONSE = 1'b1;

  // actions
  localparam logic [ACT_W-1:0] ACT_SELECT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PREPARE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MORE     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COMPLETE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FAILED   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_IGNORED  = 3'd6;

  // sequencer phases
  localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PH_W-1:0] PH_SELECT  = 2'd1;
  localparam logic [PH_W-1:0] PH_PREPARE = 2'd2;
  localparam logic [PH_W-1:0] PH_READ    = 2'd3;

  // card status words
  localparam logic [SW_W-1:0] SW_OK   = 16'h9100;
  localparam logic [SW_W-1:0] SW_MORE = 16'h91AF;

  // command bytes
  localparam logic [BYTE_W-1:0] INS_SELECT   = 8'h5A;
  localparam logic [BYTE_W-1:0] INS_PREPARE  = 8'hF5;
  localparam logic [BYTE_W-1:0] INS_MORE     = 8'hAF;
  localparam logic [BYTE_W-1:0] FILE_SELECT  = 8'h01;
  localparam logic [DLEN_W-1:0] DLEN_SELECT  = 3'd3;
  localparam logic [DLEN_W-1:0] DLEN_PREPARE = 3'd1;
  localparam logic [DLEN_W-1:0] DLEN_MORE    = 3'd0;

  typedef struct packed {
    logic [BYTE_W-1:0] file;
    logic [BYTE_W-1:0] ins;
    logic [DLEN_W-1:0] rdlen;
    logic [7:0]        expect_len;   // 0 when no fixed size
    logic              rec16;        // size must be a multiple of 16
    logic              required;
  } blk_info_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BYTE_W-1:0]  cmd_ins;
    logic [BYTE_W-1:0]  file_id;
    logic [DLEN_W-1:0]  cmd_data_len;
    logic [BLK_W-1:0]   block_number;
    logic [COUNT_W-1:0] bytes_so_far;
  } res_t;

  function automatic blk_info_t blk_info(input logic [BLK_W-1:0] b);
    blk_info_t r;
    r = '0;
    case (b)
      3'd0: r = '{file: 8'h07, ins: 8'hBD, rdlen: 3'd7, expect_len: 8'd32,
                  rec16: 1'b0, required: 1'b1};
      3'd1: r = '{file: 8'h04, ins: 8'hBD, rdlen: 3'd7, expect_len: 8'd96,
                  rec16: 1'b0, required: 1'b1};
      3'd2: r = '{file: 8'h02, ins: 8'hBD, rdlen: 3'd7, expect_len: 8'd96,
                  rec16: 1'b0, required: 1'b1};
      3'd3: r = '{file: 8'h03, ins: 8'hBB, rdlen: 3'd7, expect_len: 8'd0,
                  rec16: 1'b1, required: 1'b1};
      3'd4: r = '{file: 8'h01, ins: 8'h6C, rdlen: 3'd1, expect_len: 8'd4,
                  rec16: 1'b0, required: 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/cbrs_req_if.sv -----
// ----------------------------------------------------------------------------
// cbrs_req_if: request channel of the card block read sequencer
// Start requests and card responses, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbrs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic                         transport_error;
  logic [cbrs_pkg::SW_W-1:0]    status_word;
  logic [cbrs_pkg::CHUNK_W-1:0] chunk_length;

  modport source (output valid, output req_type, output transport_error,
                  output status_word, output chunk_length, input ready);
  modport sink   (input valid, input req_type, input transport_error,
                  input status_word, input chunk_length, output ready);
endinterface

// ----- hdl/cbrs_res_if.sv -----
// ----------------------------------------------------------------------------
// cbrs_res_if: result channel of the card block read sequencer
// Next command or final verdict, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbrs_res_if;
  logic                         valid;
  logic                         ready;
  logic [cbrs_pkg::ACT_W-1:0]   action;
  logic [cbrs_pkg::BYTE_W-1:0]  cmd_ins;
  logic [cbrs_pkg::BYTE_W-1:0]  file_id;
  logic [cbrs_pkg::DLEN_W-1:0]  cmd_data_len;
  logic [cbrs_pkg::BLK_W-1:0]   block_number;
  logic [cbrs_pkg::COUNT_W-1:0] bytes_so_far;

  modport source (output valid, output action, output cmd_ins, output file_id,
                  output cmd_data_len, output block_number, output bytes_so_far,
                  input ready);
  modport sink   (input valid, input action, input cmd_ins, input file_id,
                  input cmd_data_len, input block_number, input bytes_so_far,
                  output ready);
endinterface

// ----- hdl/card_block_read_sequencer.sv -----
// Sequences the reading of five fixed file blocks from a contactless card. A
// start request yields a select command; every card response request yields
// the next command (prepare, read, read more) or the verdict (complete,
// failed), or ignored when it does not fit the current phase. Exactly one
// result per request. Throughput is one request per clock unless a held
// result stalls it. A request passes the request register, then the result
// register, with the response decode and saturating byte count between
// them. The phase, block index and byte count update as a request moves into
// the result register, so the next request sees the new state.
// ----------------------------------------------------------------------------
// card_block_read_sequencer: top level
// Request register, response decode with phase/block/length state, result
// register.
// ----------------------------------------------------------------------------
module card_block_read_sequencer #(
  parameter int LENGTH_BITS = 12
) (
  input logic         clk,
  input logic         rst_n,
  cbrs_req_if.sink    in_req,
  cbrs_res_if.source  out_res
);

  localparam int CW = LENGTH_BITS + 1;
  localparam logic [LENGTH_BITS-1:0] MAX_LEN = '1;

  // request register
  logic                         in_v_r;
  logic                         in_type_r;
  logic                         in_terr_r;
  logic [cbrs_pkg::SW_W-1:0]    in_sw_r;
  logic [cbrs_pkg::CHUNK_W-1:0] in_chunk_r;

  // result register
  logic           out_v_r;
  cbrs_pkg::res_t res_r;
  cbrs_pkg::res_t res_nxt;

  // sequencer state
  logic [cbrs_pkg::PH_W-1:0]  phase_r, phase_nxt;
  logic [cbrs_pkg::BLK_W-1:0] block_index_r, block_index_nxt;
  logic [LENGTH_BITS-1:0]     block_length_r, block_length_nxt;

  logic                       advance;
  logic                       in_ready;
  logic [cbrs_pkg::BLK_W-1:0] idx_inc;
  cbrs_pkg::blk_info_t        blk, nblk, blk0;
  logic [LENGTH_BITS-1:0]     room;
  logic [LENGTH_BITS-1:0]     len_upd;
  logic                       len_bad;
  logic                       do_next;
  logic                       do_fail;
  logic [LENGTH_BITS-1:0]     fail_len;

  assign advance  = in_v_r && (!out_v_r || out_res.ready);
  assign in_ready = !in_v_r || advance;
  assign in_req.ready = in_ready;

  assign out_res.valid        = out_v_r;
  assign out_res.action       = res_r.action;
  assign out_res.cmd_ins      = res_r.cmd_ins;
  assign out_res.file_id      = res_r.file_id;
  assign out_res.cmd_data_len = res_r.cmd_data_len;
  assign out_res.block_number = res_r.block_number;
  assign out_res.bytes_so_far = res_r.bytes_so_far;

  assign idx_inc = block_index_r + 3'd1;
  assign blk     = cbrs_pkg::blk_info(block_index_r);
  assign nblk    = cbrs_pkg::blk_info(idx_inc);
  assign blk0    = cbrs_pkg::blk_info('0);

  // saturating byte count of a read response
  assign room    = MAX_LEN - block_length_r;
  assign len_upd = (CW'(in_chunk_r) >= {1'b0, room}) ? MAX_LEN
                 : block_length_r + LENGTH_BITS'(in_chunk_r);
  assign len_bad = ((blk.expect_len != 8'd0) &&
                    (len_upd != LENGTH_BITS'(blk.expect_len))) ||
                   (blk.rec16 && (len_upd[3:0] != 4'd0));

  always_comb begin
    phase_nxt        = phase_r;
    block_index_nxt  = block_index_r;
    block_length_nxt = block_length_r;
    res_nxt          = '0;
    res_nxt.action   = cbrs_pkg::ACT_IGNORED;
    do_next          = 1'b0;
    do_fail          = 1'b0;
    fail_len         = block_length_r;

    if (in_type_r == cbrs_pkg::REQ_START) begin
      if (phase_r == cbrs_pkg::PH_IDLE) begin
        block_index_nxt      = '0;
        block_length_nxt     = '0;
        phase_nxt            = cbrs_pkg::PH_SELECT;
        res_nxt.action       = cbrs_pkg::ACT_SELECT;
        res_nxt.cmd_ins      = cbrs_pkg::INS_SELECT;
        res_nxt.file_id      = cbrs_pkg::FILE_SELECT;
        res_nxt.cmd_data_len = cbrs_pkg::DLEN_SELECT;
      end
    end else if (phase_r == cbrs_pkg::PH_IDLE) begin
      res_nxt.action = cbrs_pkg::ACT_IGNORED;
    end else if (in_terr_r) begin
      do_fail = 1'b1;
    end else if (phase_r == cbrs_pkg::PH_SELECT) begin
      if (in_sw_r == cbrs_pkg::SW_OK) begin
        block_index_nxt      = '0;
        block_length_nxt     = '0;
        phase_nxt            = cbrs_pkg::PH_PREPARE;
        res_nxt.action       = cbrs_pkg::ACT_PREPARE;
        res_nxt.cmd_ins      = cbrs_pkg::INS_PREPARE;
        res_nxt.file_id      = blk0.file;
        res_nxt.cmd_data_len = cbrs_pkg::DLEN_PREPARE;
      end else begin
        do_fail = 1'b1;
      end
    end else if (block_index_r >= cbrs_pkg::NBLOCKS) begin
      do_fail = 1'b1;
    end else if (phase_r == cbrs_pkg::PH_PREPARE) begin
      if (in_sw_r == cbrs_pkg::SW_OK) begin
        block_length_nxt     = '0;
        phase_nxt            = cbrs_pkg::PH_READ;
        res_nxt.action       = cbrs_pkg::ACT_READ;
        res_nxt.cmd_ins      = blk.ins;
        res_nxt.file_id      = blk.file;
        res_nxt.cmd_data_len = blk.rdlen;
        res_nxt.block_number = block_index_r;
      end else if (!blk.required) begin
        do_next = 1'b1;
      end else begin
        do_fail = 1'b1;
      end
    end else begin
      // waiting for read data
      block_length_nxt = len_upd;
      fail_len         = len_upd;
      if (in_sw_r == cbrs_pkg::SW_MORE) begin
        res_nxt.action       = cbrs_pkg::ACT_MORE;
        res_nxt.cmd_ins      = cbrs_pkg::INS_MORE;
        res_nxt.cmd_data_len = cbrs_pkg::DLEN_MORE;
        res_nxt.block_number = block_index_r;
        res_nxt.bytes_so_far = cbrs_pkg::COUNT_W'(len_upd);
      end else if (in_sw_r == cbrs_pkg::SW_OK) begin
        if (len_bad && blk.required) begin
          do_fail = 1'b1;
        end else begin
          do_next = 1'b1;
        end
      end else if (!blk.required) begin
        do_next = 1'b1;
      end else begin
        do_fail = 1'b1;
      end
    end

    if (do_fail) begin
      phase_nxt            = cbrs_pkg::PH_IDLE;
      res_nxt              = '0;
      res_nxt.action       = cbrs_pkg::ACT_FAILED;
      res_nxt.block_number = block_index_r;
      res_nxt.bytes_so_far = cbrs_pkg::COUNT_W'(fail_len);
    end else if (do_next) begin
      block_index_nxt  = idx_inc;
      block_length_nxt = '0;
      res_nxt          = '0;
      if (idx_inc >= cbrs_pkg::NBLOCKS) begin
        phase_nxt      = cbrs_pkg::PH_IDLE;
        res_nxt.action = cbrs_pkg::ACT_COMPLETE;
      end else begin
        phase_nxt            = cbrs_pkg::PH_PREPARE;
        res_nxt.action       = cbrs_pkg::ACT_PREPARE;
        res_nxt.cmd_ins      = cbrs_pkg::INS_PREPARE;
        res_nxt.file_id      = nblk.file;
        res_nxt.cmd_data_len = cbrs_pkg::DLEN_PREPARE;
        res_nxt.block_number = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      phase_r        <= cbrs_pkg::PH_IDLE;
      block_index_r  <= '0;
      block_length_r <= '0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_req.valid;
      end
      if (advance) begin
        out_v_r        <= 1'b1;
        phase_r        <= phase_nxt;
        block_index_r  <= block_index_nxt;
        block_length_r <= block_length_nxt;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_req.valid) begin
      in_type_r  <= in_req.req_type;
      in_terr_r  <= in_req.transport_error;
      in_sw_r    <= in_req.status_word;
      in_chunk_r <= in_req.chunk_length;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  // a verdict always returns the sequencer to idle
  a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.action == cbrs_pkg::ACT_COMPLETE ||
                res_nxt.action == cbrs_pkg::ACT_FAILED)
    |=> phase_r == cbrs_pkg::PH_IDLE)
    else $error("verdict did not return to idle");

  // while a run is active the block index stays inside the table
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != cbrs_pkg::PH_IDLE |-> block_index_r < cbrs_pkg::NBLOCKS)
    else $error("block index out of range in active phase");

  // a select result starts a run at block zero
  a_select_start: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.action == cbrs_pkg::ACT_SELECT
    |=> phase_r == cbrs_pkg::PH_SELECT && block_index_r == '0 &&
        block_length_r == '0)
    else $error("select did not start a run");

  // a read result leaves the sequencer waiting for read data with no bytes
  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.action == cbrs_pkg::ACT_READ
    |=> phase_r == cbrs_pkg::PH_READ && block_length_r == '0)
    else $error("read command without read phase");

  // the request side only stalls while a request is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r)
    else $error("request side stalled with nothing held");
`endif

endmodule

// ----- sim/tb_card_block_read_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_card_block_read_sequencer: testbench of the card block read sequencer
// Drives start and card response requests, keeps its own model of the phase,
// block index and saturating byte count, and checks every result field by
// field in order. Directed tests first, then well-formed read sequences with
// random content, noise and errors under four idling patterns.
// ----------------------------------------------------------------------------
module tb_card_block_read_sequencer;

  localparam int LEN_BITS = 12;
  localparam int LEN_MAX  = (1 << LEN_BITS) - 1;

  // per-block tables, block 0 in the low bits
  localparam logic [39:0] BLK_FILE     = {8'h01, 8'h03, 8'h02, 8'h04, 8'h07};
  localparam logic [39:0] BLK_INS      = {8'h6C, 8'hBB, 8'hBD, 8'hBD, 8'hBD};
  localparam logic [14:0] BLK_RDLEN    = {3'd1, 3'd7, 3'd7, 3'd7, 3'd7};
  localparam logic [59:0] BLK_SIZE     = {12'd4, 12'd0, 12'd96, 12'd96, 12'd32};
  localparam logic [59:0] BLK_RECORD   = {12'd0, 12'd16, 12'd0, 12'd0, 12'd0};
  localparam logic [4:0]  BLK_REQUIRED = 5'b01111;

  logic clk = 1'b0;
  logic rst_n;

  cbrs_req_if req_ch ();
  cbrs_res_if res_ch ();

  card_block_read_sequencer #(.LENGTH_BITS(LEN_BITS)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the sequencer
  logic [cbrs_pkg::PH_W-1:0]  seq_phase;
  logic [cbrs_pkg::BLK_W-1:0] seq_blk;
  int                         seq_len;

  cbrs_pkg::res_t awaited_cmds[$];
  cbrs_pkg::res_t last_expected;
  cbrs_pkg::res_t want_res;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   n_errors;
  int   n_requests;
  int   n_results;
  int   act_seen [0:7];

  function automatic cbrs_pkg::res_t abort_read();
    cbrs_pkg::res_t r;
    r = '0;
    r.action       = cbrs_pkg::ACT_FAILED;
    r.block_number = seq_blk;
    r.bytes_so_far = seq_len[cbrs_pkg::COUNT_W-1:0];
    seq_phase      = cbrs_pkg::PH_IDLE;
    return r;
  endfunction

  function automatic cbrs_pkg::res_t open_block();
    cbrs_pkg::res_t r;
    int   b;
    r = '0;
    b = seq_blk;
    seq_len = 0;
    if (seq_blk >= cbrs_pkg::NBLOCKS) begin
      r.action  = cbrs_pkg::ACT_COMPLETE;
      seq_phase = cbrs_pkg::PH_IDLE;
    end else begin
      r.action       = cbrs_pkg::ACT_PREPARE;
      r.cmd_ins      = cbrs_pkg::INS_PREPARE;
      r.file_id      = BLK_FILE[b*8 +: 8];
      r.cmd_data_len = cbrs_pkg::DLEN_PREPARE;
      r.block_number = seq_blk;
      seq_phase      = cbrs_pkg::PH_PREPARE;
    end
    return r;
  endfunction

  function automatic cbrs_pkg::res_t advance_block();
    seq_blk = seq_blk + 1'b1;
    return open_block();
  endfunction

  // next command or verdict for one accepted request, updates the model state
  function automatic cbrs_pkg::res_t sequence_card_read(
      input logic rt, input logic te,
      input logic [cbrs_pkg::SW_W-1:0] sw,
      input logic [cbrs_pkg::CHUNK_W-1:0] ch);
    cbrs_pkg::res_t r;
    int   b;
    logic bad;
    r = '0;
    r.action = cbrs_pkg::ACT_IGNORED;
    b = seq_blk;
    if (rt == cbrs_pkg::REQ_START) begin
      if (seq_phase == cbrs_pkg::PH_IDLE) begin
        seq_blk        = '0;
        seq_len        = 0;
        seq_phase      = cbrs_pkg::PH_SELECT;
        r.action       = cbrs_pkg::ACT_SELECT;
        r.cmd_ins      = cbrs_pkg::INS_SELECT;
        r.file_id      = cbrs_pkg::FILE_SELECT;
        r.cmd_data_len = cbrs_pkg::DLEN_SELECT;
      end
    end else if (seq_phase != cbrs_pkg::PH_IDLE) begin
      if (te) begin
        r = abort_read();
      end else if (seq_phase == cbrs_pkg::PH_SELECT) begin
        if (sw == cbrs_pkg::SW_OK) begin
          seq_blk = '0;
          r = open_block();
        end else begin
          r = abort_read();
        end
      end else if (seq_blk >= cbrs_pkg::NBLOCKS) begin
        r = abort_read();
      end else if (seq_phase == cbrs_pkg::PH_PREPARE) begin
        if (sw == cbrs_pkg::SW_OK) begin
          seq_len        = 0;
          seq_phase      = cbrs_pkg::PH_READ;
          r.action       = cbrs_pkg::ACT_READ;
          r.cmd_ins      = BLK_INS[b*8 +: 8];
          r.file_id      = BLK_FILE[b*8 +: 8];
          r.cmd_data_len = BLK_RDLEN[b*3 +: 3];
          r.block_number = seq_blk;
        end else if (!BLK_REQUIRED[b]) begin
          r = advance_block();
        end else begin
          r = abort_read();
        end
      end else begin
        // saturating byte count of the read data
        if (ch >= LEN_MAX - seq_len) seq_len = LEN_MAX;
        else seq_len = seq_len + ch;
        if (sw == cbrs_pkg::SW_MORE) begin
          r.action       = cbrs_pkg::ACT_MORE;
          r.cmd_ins      = cbrs_pkg::INS_MORE;
          r.cmd_data_len = cbrs_pkg::DLEN_MORE;
          r.block_number = seq_blk;
          r.bytes_so_far = seq_len[cbrs_pkg::COUNT_W-1:0];
        end else if (sw == cbrs_pkg::SW_OK) begin
          bad = (BLK_SIZE[b*12 +: 12] != 0 && seq_len != BLK_SIZE[b*12 +: 12]) ||
                (BLK_RECORD[b*12 +: 12] != 0 && (seq_len % BLK_RECORD[b*12 +: 12]) != 0);
          if (bad && BLK_REQUIRED[b]) r = abort_read();
          else r = advance_block();
        end else if (!BLK_REQUIRED[b]) begin
          r = advance_block();
        end else begin
          r = abort_read();
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [cbrs_pkg::SW_W-1:0] odd_status();
    logic [cbrs_pkg::SW_W-1:0] s;
    s = cbrs_pkg::SW_W'($urandom);
    while (s == cbrs_pkg::SW_OK || s == cbrs_pkg::SW_MORE) s = cbrs_pkg::SW_W'($urandom);
    return s;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      n_results++;
      act_seen[res_ch.action]++;
      if (awaited_cmds.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, expected none, got %0h",
                 $time, {res_ch.action, res_ch.cmd_ins, res_ch.file_id,
                 res_ch.cmd_data_len, res_ch.block_number, res_ch.bytes_so_far});
      end else begin
        want_res = awaited_cmds.pop_front();
        check_field("action", want_res.action, res_ch.action);
        check_field("cmd_ins", want_res.cmd_ins, res_ch.cmd_ins);
        check_field("file_id", want_res.file_id, res_ch.file_id);
        check_field("cmd_data_len", want_res.cmd_data_len, res_ch.cmd_data_len);
        check_field("block_number", want_res.block_number, res_ch.block_number);
        check_field("bytes_so_far", want_res.bytes_so_far, res_ch.bytes_so_far);
      end
    end
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(input logic rt, input logic te,
                              input logic [cbrs_pkg::SW_W-1:0] sw,
                              input logic [cbrs_pkg::CHUNK_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= rt;
    req_ch.transport_error <= te;
    req_ch.status_word     <= sw;
    req_ch.chunk_length    <= ch;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    last_expected = sequence_card_read(rt, te, sw, ch);
    awaited_cmds.push_back(last_expected);
    n_requests++;
  endtask

  // lets the pipeline run dry with the request side idle
  task automatic wait_quiet();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (awaited_cmds.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_cmds.size() != 0) begin
      n_errors++;
      $display("%0t: results missing, expected %0d more, got none", $time,
               awaited_cmds.size());
      awaited_cmds.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic test_idle_responses();
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b1, 16'hFFFF, 9'h1FF);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, 16'h0000, 9'h000);
  endtask

  // all five blocks read cleanly, chunk counts of select and prepare ignored
  task automatic test_clean_read();
    send_request(cbrs_pkg::REQ_START, 1'b0, 16'h0000, 9'h000);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd511);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd300);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_MORE, 9'd20);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd12);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd0);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd96);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd0);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd96);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd0);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd0);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd0);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_OK, 9'd4);
  endtask

  task automatic test_busy_and_errors();
    send_request(cbrs_pkg::REQ_START, 1'b0, 16'h0000, 9'h000);
    send_request(cbrs_pkg::REQ_START, 1'b1, cbrs_pkg::SW_OK, 9'h1FF);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b1, cbrs_pkg::SW_OK, 9'h000);
    send_request(cbrs_pkg::REQ_START, 1'b0, 16'h0000, 9'h000);
    send_request(cbrs_pkg::REQ_RESPONSE, 1'b0, cbrs_pkg::SW_MORE, 9'h0AA);
  endtask

  // mostly well-formed sequences, some noise, errors and bad sizes
  task automatic test_random_traffic(input int n_items);
    int              k;
    int              roll;
    int              pick;
    int              rem;
    int              goal;
    int              b;
    bit              goal_valid;
    logic            rt;
    logic            te;
    logic [cbrs_pkg::SW_W-1:0]    sw;
    logic [cbrs_pkg::CHUNK_W-1:0] ch;
    k = 0;
    goal = 0;
    goal_valid = 1'b0;
    while (k < n_items) begin
      if (seq_phase != cbrs_pkg::PH_READ) goal_valid = 1'b0;
      roll = $urandom_range(999);
      rt = cbrs_pkg::REQ_RESPONSE;
      te = 1'b0;
      sw = cbrs_pkg::SW_OK;
      ch = cbrs_pkg::CHUNK_W'($urandom_range(511));
      b  = seq_blk;
      if (roll < 30) begin
        rt = 1'($urandom_range(1));
        te = 1'($urandom_range(1));
        sw = cbrs_pkg::SW_W'($urandom);
      end else if (roll < 45) begin
        te = 1'b1;
      end else begin
        case (seq_phase)
          cbrs_pkg::PH_IDLE: rt = cbrs_pkg::REQ_START;
          cbrs_pkg::PH_SELECT: if (roll < 60) sw = odd_status();
          cbrs_pkg::PH_PREPARE: if (roll < 70 || (b == 4 && roll < 300)) sw = odd_status();
          default: begin
            if (!goal_valid) begin
              pick = $urandom_range(99);
              if (pick < 4) goal = LEN_MAX + 1000;   // run into saturation
              else if (pick < 12) goal = $urandom_range(200);
              else if (b == 3) goal = 16 * $urandom_range(20);
              else goal = BLK_SIZE[b*12 +: 12];
              goal_valid = 1'b1;
            end
            if (roll < 60) begin
              sw = odd_status();
            end else if (seq_len >= goal || seq_len == LEN_MAX) begin
              ch = '0;
            end else begin
              rem = goal - seq_len;
              if (goal > LEN_MAX) ch = cbrs_pkg::CHUNK_W'($urandom_range(256, 511));
              else ch = cbrs_pkg::CHUNK_W'($urandom_range(1, (rem < 511) ? rem : 511));
              if (ch != rem || $urandom_range(1)) sw = cbrs_pkg::SW_MORE;
            end
          end
        endcase
      end
      send_request(rt, te, sw, ch);
      if (last_expected.action != cbrs_pkg::ACT_IGNORED) k++;
    end
  endtask

  initial begin
    rst_n                  <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= cbrs_pkg::REQ_START;
    req_ch.transport_error <= 1'b0;
    req_ch.status_word     <= '0;
    req_ch.chunk_length    <= '0;
    seq_phase      = cbrs_pkg::PH_IDLE;
    seq_blk        = '0;
    seq_len        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_errors       = 0;
    n_requests     = 0;
    n_results      = 0;
    foreach (act_seen[i]) act_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_responses();
    test_clean_read();
    test_busy_and_errors();
    wait_quiet();

    test_random_traffic(200);
    wait_quiet();
    send_idle_pct = 82;
    test_random_traffic(200);
    wait_quiet();
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    test_random_traffic(200);
    wait_quiet();
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    test_random_traffic(200);
    wait_quiet();

    $display("%0d requests sent, %0d results checked, %0d mismatches",
             n_requests, n_results, n_errors);
    $display("reads complete %0d, failed %0d, ignored %0d, read-more steps %0d",
             act_seen[cbrs_pkg::ACT_COMPLETE], act_seen[cbrs_pkg::ACT_FAILED],
             act_seen[cbrs_pkg::ACT_IGNORED], act_seen[cbrs_pkg::ACT_MORE]);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout, results still outstanding: %0d", awaited_cmds.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cbrs_pkg.sv
hdl/cbrs_req_if.sv
hdl/cbrs_res_if.sv
hdl/card_block_read_sequencer.sv
sim/tb_card_block_read_sequencer.sv
